/* rtl/assert_macros.svh */
// Assertion macros shared by the string hash RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/msh_pkg.sv */
// Package with types, mode codes and constants of the multi-mode string hash.
package msh_pkg;

  // Algorithm select codes held in the mode register.
  localparam logic [4:0] MODE_DJB2   = 5'd0;
  localparam logic [4:0] MODE_SDBM   = 5'd1;
  localparam logic [4:0] MODE_ADD    = 5'd2;
  localparam logic [4:0] MODE_RS     = 5'd3;
  localparam logic [4:0] MODE_JS     = 5'd4;
  localparam logic [4:0] MODE_PJW    = 5'd5;
  localparam logic [4:0] MODE_ELF    = 5'd6;
  localparam logic [4:0] MODE_BKDR   = 5'd7;
  localparam logic [4:0] MODE_MABKDR = 5'd8;
  localparam logic [4:0] MODE_AP     = 5'd9;
  localparam logic [4:0] MODE_LCG    = 5'd10;
  localparam logic [4:0] MODE_ROT13  = 5'd11;
  localparam logic [4:0] MODE_OAAT   = 5'd12;
  localparam logic [4:0] MODE_FNV1   = 5'd13;
  localparam logic [4:0] MODE_FNV1A  = 5'd14;
  localparam logic [4:0] MODE_WSUM   = 5'd15;
  localparam logic [4:0] MODE_LOAAT  = 5'd16;

  // Configuration register indexes.
  localparam logic CFG_IDX_MODE = 1'b0;
  localparam logic CFG_IDX_BKDR = 1'b1;

  localparam logic [4:0]  MODE_RESET = MODE_DJB2;
  localparam logic [31:0] BKDR_RESET = 32'd131313;

  localparam logic [31:0] DJB2_INIT  = 32'd5381;
  localparam logic [31:0] JS_INIT    = 32'd1315423911;
  localparam logic [31:0] FNV_OFFSET = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME  = 32'h01000193;
  localparam logic [31:0] RS_INIT    = 32'd63689;
  localparam logic [31:0] RS_MULT    = 32'd378551;
  localparam logic [31:0] LCG_MULT   = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam logic [31:0] WSUM_BIAS  = 32'd119;
  localparam logic [31:0] PJW_HIGH   = 32'hF0000000;
  localparam logic [31:0] PJW_LOW    = 32'h0FFFFFFF;

  typedef struct packed {
    logic [4:0]  mode;
    logic [31:0] bkdr_mult;
  } cfg_t;

  typedef struct packed {
    logic [31:0] running_hash;
    logic [31:0] rs_factor;
    logic [31:0] position;
    logic        in_string;
  } hstate_t;

endpackage

/* rtl/msh_cfg.sv */
// Configuration register file: mode select and BKDR multiplier.
module msh_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  output msh_pkg::cfg_t    cfg_o
);

  msh_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        msh_pkg::CFG_IDX_MODE: cfg_nxt.mode      = cfg_data[4:0];
        msh_pkg::CFG_IDX_BKDR: cfg_nxt.bkdr_mult = cfg_data;
        default:               cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= msh_pkg::MODE_RESET;
      cfg_r.bkdr_mult <= msh_pkg::BKDR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/msh_step.sv */
// One-byte update of the running hash state for the selected algorithm.
module msh_step (
  input  msh_pkg::cfg_t    cfg_i,
  input  msh_pkg::hstate_t cur_i,
  input  logic [7:0]       byte_i,
  output logic [31:0]      hash_cur_o,
  output msh_pkg::hstate_t nxt_o
);

  logic [31:0] h;
  logic [31:0] c;
  logic [31:0] i;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_p;
  logic [7:0]  c_fold;
  logic [31:0] i_wt;
  logic [31:0] wt_prod;
  logic [31:0] shl4;
  logic [31:0] rot_t;
  logic [31:0] oaat_c;
  logic [31:0] oaat_a;
  logic [31:0] oaat_b;
  logic        is_upper;
  logic        is_lower;
  logic [31:0] h_new;

  // Hash seen by this byte: the mode's start value outside a string.
  always_comb begin
    if (cur_i.in_string) begin
      h = cur_i.running_hash;
    end else begin
      case (cfg_i.mode)
        msh_pkg::MODE_DJB2:  h = msh_pkg::DJB2_INIT;
        msh_pkg::MODE_JS:    h = msh_pkg::JS_INIT;
        msh_pkg::MODE_FNV1:  h = msh_pkg::FNV_OFFSET;
        msh_pkg::MODE_FNV1A: h = msh_pkg::FNV_OFFSET;
        default:             h = '0;
      endcase
    end
  end

  assign hash_cur_o = h;
  assign c          = {24'd0, byte_i};
  assign i          = cur_i.position;

  // Shared 32x32 multiplier for the RS, BKDR, maBKDR, LCG and FNV modes.
  always_comb begin
    mul_a = (cfg_i.mode == msh_pkg::MODE_FNV1A) ? (h ^ c) : h;
    case (cfg_i.mode)
      msh_pkg::MODE_RS:     mul_b = cur_i.rs_factor;
      msh_pkg::MODE_BKDR:   mul_b = cfg_i.bkdr_mult;
      msh_pkg::MODE_MABKDR: mul_b = cfg_i.bkdr_mult;
      msh_pkg::MODE_LCG:    mul_b = msh_pkg::LCG_MULT;
      default:              mul_b = msh_pkg::FNV_PRIME;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Case-folded byte times its position weight.
  assign is_upper = (byte_i >= 8'h41) && (byte_i <= 8'h5A);
  assign is_lower = (byte_i >= 8'h61) && (byte_i <= 8'h7A);
  assign c_fold   = is_upper ? (byte_i + 8'h20) : byte_i;
  assign i_wt     = i + msh_pkg::WSUM_BIAS;
  assign wt_prod  = 32'({24'd0, c_fold} * i_wt);

  assign shl4  = (h << 4) + c;
  assign rot_t = h + {{24{byte_i[7]}}, byte_i};

  // One-at-a-time mixing step; letters-only mode feeds the letter offset.
  always_comb begin
    if (cfg_i.mode == msh_pkg::MODE_LOAAT) begin
      oaat_c = is_upper ? (c - 32'h41) : (c - 32'h61);
    end else begin
      oaat_c = c;
    end
    oaat_a = h + oaat_c;
    oaat_b = oaat_a + (oaat_a << 10);
  end

  always_comb begin
    case (cfg_i.mode)
      msh_pkg::MODE_DJB2:   h_new = (h << 5) + h + c;
      msh_pkg::MODE_SDBM:   h_new = c + (h << 6) + (h << 16) - h;
      msh_pkg::MODE_ADD:    h_new = h + c;
      msh_pkg::MODE_RS:     h_new = mul_p + c;
      msh_pkg::MODE_JS:     h_new = h ^ ((h << 5) + c + (h >> 2));
      msh_pkg::MODE_PJW, msh_pkg::MODE_ELF: begin
        // Both fold the top nibble down and then clear it.
        if ((shl4 & msh_pkg::PJW_HIGH) != '0) begin
          h_new = (shl4 ^ ((shl4 & msh_pkg::PJW_HIGH) >> 24)) & msh_pkg::PJW_LOW;
        end else begin
          h_new = shl4;
        end
      end
      msh_pkg::MODE_BKDR:   h_new = mul_p + c;
      msh_pkg::MODE_MABKDR: h_new = mul_p + c + i;
      msh_pkg::MODE_AP: begin
        if (!i[0]) begin
          h_new = h ^ ((h << 7) ^ c ^ (h >> 3));
        end else begin
          h_new = h ^ ~((h << 11) ^ c ^ (h >> 5));
        end
      end
      msh_pkg::MODE_LCG:    h_new = mul_p + c + msh_pkg::LCG_ADD;
      msh_pkg::MODE_ROT13:  h_new = rot_t - {rot_t[18:0], rot_t[31:19]};
      msh_pkg::MODE_OAAT:   h_new = oaat_b ^ (oaat_b >> 6);
      msh_pkg::MODE_FNV1:   h_new = mul_p ^ c;
      msh_pkg::MODE_FNV1A:  h_new = mul_p;
      msh_pkg::MODE_WSUM:   h_new = h + wt_prod;
      msh_pkg::MODE_LOAAT: begin
        if (is_upper || is_lower) begin
          h_new = oaat_b ^ (oaat_b >> 6);
        end else begin
          h_new = h;
        end
      end
      default:              h_new = h;
    endcase
  end

  always_comb begin
    nxt_o.running_hash = h_new;
    nxt_o.rs_factor    = cur_i.rs_factor * msh_pkg::RS_MULT;
    nxt_o.position     = cur_i.position + 32'd1;
    nxt_o.in_string    = 1'b1;
  end

endmodule

/* rtl/msh_finish.sv */
// Final avalanche applied to the hash of the one-at-a-time modes.
module msh_finish (
  input  logic [4:0]  mode_i,
  input  logic [31:0] hash_i,
  output logic [31:0] hash_o
);

  logic [31:0] f1;
  logic [31:0] f2;
  logic [31:0] f3;

  assign f1 = hash_i + (hash_i << 3);
  assign f2 = f1 ^ (f1 >> 11);
  assign f3 = f2 + (f2 << 15);

  always_comb begin
    case (mode_i)
      msh_pkg::MODE_OAAT:  hash_o = f3;
      msh_pkg::MODE_LOAAT: hash_o = f3;
      default:             hash_o = hash_i;
    endcase
  end

endmodule

/* rtl/multi_mode_string_hash.sv */
// Top level of the multi-mode 32-bit string hash.
//
// The input channel takes one string byte per word (in_valid, in_stall,
// in_data_byte). Each nonzero byte is folded into a running 32-bit hash by
// the algorithm that the mode register selects. A zero byte ends the string:
// the final hash, with the closing mix of the one-at-a-time modes applied,
// goes out as one word on the result channel (out_valid, out_stall,
// out_hash_value), and the running state returns to its idle values.
//
// A byte is captured in the input register. As it leaves, one pass of logic
// (a shared 32x32 multiplier, further multipliers and adds) updates the
// state and, for a zero byte, loads the result register, so a hash word
// passes the input and then the result register. One byte is taken every
// cycle while in_stall is low; the per-byte state update sets that rate.
//
// When the receiver stalls, the result register holds its word. Bytes keep
// flowing until a second zero byte reaches the input register; only then is
// in_stall raised, until the pending word is taken.
//
// The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready. Index 0 is the mode, index 1 the BKDR multiplier; write them
// only while no string is in flight. Synchronous reset (rst_n low) clears
// both registers to their defaults, empties the pipeline and idles the state.
`include "assert_macros.svh"

module multi_mode_string_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  msh_pkg::cfg_t    cfg;
  msh_pkg::hstate_t st_r, st_nxt;
  msh_pkg::hstate_t st_step;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r, s1_byte_nxt;
  logic        s1_term;
  logic        s1_fire;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;
  logic [31:0] hash_cur;
  logic [31:0] hash_final;

  msh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  msh_step u_step (
    .cfg_i      (cfg),
    .cur_i      (st_r),
    .byte_i     (s1_byte_r),
    .hash_cur_o (hash_cur),
    .nxt_o      (st_step)
  );

  msh_finish u_finish (
    .mode_i (cfg.mode),
    .hash_i (hash_cur),
    .hash_o (hash_final)
  );

  // The input register can only be held up by a terminator that has
  // nowhere to put its hash word.
  assign s1_term  = (s1_byte_r == 8'd0);
  assign in_stall = s1_valid_r && s1_term && out_valid_r && out_stall;
  assign s1_fire  = s1_valid_r && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
      s1_byte_nxt  = in_data_byte;
    end
  end

  // State update: a terminator returns to the idle values.
  always_comb begin
    st_nxt = st_r;
    if (s1_fire) begin
      if (s1_term) begin
        st_nxt.running_hash = '0;
        st_nxt.rs_factor    = msh_pkg::RS_INIT;
        st_nxt.position     = '0;
        st_nxt.in_string    = 1'b0;
      end else begin
        st_nxt = st_step;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;
    if (s1_fire && s1_term) begin
      out_valid_nxt = 1'b1;
      out_hash_nxt  = hash_final;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      st_r.running_hash <= '0;
      st_r.rs_factor    <= msh_pkg::RS_INIT;
      st_r.position     <= '0;
      st_r.in_string    <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r  <= s1_byte_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  `ASSERT_NEXT(a_term_clears, clk, rst_n, s1_fire && s1_term, !st_r.in_string && out_valid_r)
  `ASSERT_NEXT(a_byte_opens, clk, rst_n, s1_fire && !s1_term, st_r.in_string)
  `ASSERT_IMPLIES(a_idle_counters, clk, rst_n, !st_r.in_string, st_r.position == '0 && st_r.rs_factor == msh_pkg::RS_INIT)
  `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, s1_valid_r && out_valid_r && out_stall)
  `ASSERT_IMPLIES(a_out_source, clk, rst_n, $rose(out_valid_r), $past(s1_fire && s1_term))

endmodule

/* verif/string_hash_checker.sv */
// Checker that predicts the hash word of every string and compares it with the block's output.
module string_hash_checker
  import msh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_hash_value,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          failures,
  output int          pending_hashes,
  output int          hashes_checked
);

  localparam logic [7:0]  END_OF_STRING = 8'h00;
  localparam logic [7:0]  UPPER_A       = 8'h41;
  localparam logic [7:0]  UPPER_Z       = 8'h5A;
  localparam logic [7:0]  LOWER_A       = 8'h61;
  localparam logic [7:0]  LOWER_Z       = 8'h7A;
  localparam logic [31:0] CASE_FOLD     = 32'h20;

  logic [4:0]  cur_mode;
  logic [31:0] bkdr_mult;
  logic [31:0] run_hash;
  logic [31:0] rs_factor;
  logic [31:0] byte_pos;
  logic        mid_string;
  logic [31:0] awaited_hashes[$];

  function automatic logic [31:0] seed_value();
    case (cur_mode)
      MODE_DJB2:              return DJB2_INIT;
      MODE_JS:                return JS_INIT;
      MODE_FNV1, MODE_FNV1A:  return FNV_OFFSET;
      default:                return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] oaat_step(input logic [31:0] h, input logic [31:0] c);
    h = h + c;
    h = h + (h << 10);
    return h ^ (h >> 6);
  endfunction

  // Only the two one-at-a-time modes apply a final avalanche.
  function automatic logic [31:0] closing_mix(input logic [31:0] h);
    if (cur_mode == MODE_OAAT || cur_mode == MODE_LOAAT) begin
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
    end
    return h;
  endfunction

  function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] c;
    logic [31:0] top_nibble;
    c = {24'd0, b};
    case (cur_mode)
      MODE_DJB2:   return (h << 5) + h + c;
      MODE_SDBM:   return c + (h << 6) + (h << 16) - h;
      MODE_ADD:    return h + c;
      MODE_RS:     return h * rs_factor + c;
      MODE_JS:     return h ^ ((h << 5) + c + (h >> 2));
      MODE_PJW: begin
        h = (h << 4) + c;
        top_nibble = h & PJW_HIGH;
        if (top_nibble != 32'd0) h = (h ^ (top_nibble >> 24)) & PJW_LOW;
        return h;
      end
      MODE_ELF: begin
        h = (h << 4) + c;
        top_nibble = h & PJW_HIGH;
        if (top_nibble != 32'd0) h = (h ^ (top_nibble >> 24)) & ~top_nibble;
        return h;
      end
      MODE_BKDR:   return h * bkdr_mult + c;
      MODE_MABKDR: return h * bkdr_mult + c + byte_pos;
      MODE_AP: begin
        if (!byte_pos[0]) return h ^ ((h << 7) ^ c ^ (h >> 3));
        return h ^ ~((h << 11) ^ c ^ (h >> 5));
      end
      MODE_LCG:    return h * LCG_MULT + c + LCG_ADD;
      MODE_ROT13: begin
        // High bytes behave as signed chars here.
        c = {{24{b[7]}}, b};
        h = h + c;
        return h - {h[18:0], h[31:19]};
      end
      MODE_OAAT:   return oaat_step(h, c);
      MODE_FNV1:   return (h * FNV_PRIME) ^ c;
      MODE_FNV1A:  return (h ^ c) * FNV_PRIME;
      MODE_WSUM: begin
        if (b >= UPPER_A && b <= UPPER_Z) c = c + CASE_FOLD;
        return h + c * (byte_pos + WSUM_BIAS);
      end
      MODE_LOAAT: begin
        if (b >= UPPER_A && b <= UPPER_Z) return oaat_step(h, c - {24'd0, UPPER_A});
        if (b >= LOWER_A && b <= LOWER_Z) return oaat_step(h, c - {24'd0, LOWER_A});
        return h;
      end
      default:     return h;
    endcase
  endfunction

  always @(posedge clk) begin : watch_channels
    logic [31:0] h;
    logic [31:0] want;
    if (!rst_n) begin
      cur_mode       = MODE_RESET;
      bkdr_mult      = BKDR_RESET;
      run_hash       = 32'd0;
      rs_factor      = RS_INIT;
      byte_pos       = 32'd0;
      mid_string     = 1'b0;
      failures       = 0;
      hashes_checked = 0;
      awaited_hashes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_MODE) cur_mode = cfg_data[4:0];
        else bkdr_mult = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (awaited_hashes.size() == 0) begin
          $display("%0t: hash word %08h arrived with none expected", $time, out_hash_value);
          failures++;
        end else begin
          want = awaited_hashes.pop_front();
          if (out_hash_value !== want) begin
            $display("%0t: hash mismatch: expected %08h, actual %08h",
                     $time, want, out_hash_value);
            failures++;
          end
        end
        hashes_checked++;
      end
      if (in_valid && !in_stall) begin
        h = mid_string ? run_hash : seed_value();
        if (in_data_byte == END_OF_STRING) begin
          awaited_hashes.push_back(closing_mix(h));
          run_hash   = 32'd0;
          rs_factor  = RS_INIT;
          byte_pos   = 32'd0;
          mid_string = 1'b0;
        end else begin
          run_hash   = fold_byte(h, in_data_byte);
          rs_factor  = rs_factor * RS_MULT;
          byte_pos   = byte_pos + 32'd1;
          mid_string = 1'b1;
        end
      end
    end
    pending_hashes = awaited_hashes.size();
  end

endmodule

/* verif/multi_mode_string_hash_test.sv */
// Testbench top that drives strings and configuration into the string hash and gives the verdict.
module multi_mode_string_hash_test;
  import msh_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int CLK_PERIOD      = 2 * CLK_HALF;
  localparam int RESET_CYCLES    = 12;
  // A hash word passes the input and result registers after its zero byte;
  // the settling time after draining covers a byte still in the input register.
  localparam int SETTLE_CYCLES   = 6;
  localparam int NUM_PHASES      = 40;
  localparam int BYTES_PER_PHASE = 30;
  localparam int QUIET_PHASES    = 3;
  localparam int SQUEEZE_PHASE   = 9;
  localparam int LONG_HOLD       = 300;
  localparam int WATCHDOG_CYCLES = 400000;

  localparam logic [7:0] END_OF_STRING   = 8'h00;
  localparam logic [7:0] UPPER_A         = 8'h41;
  localparam logic [7:0] LOWER_A         = 8'h61;
  localparam logic [4:0] MODE_UNUSED_TOP = 5'd31;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_hash_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_IDX_MODE;
  logic [31:0] cfg_data = 32'd0;

  int failures;
  int pending_hashes;
  int hashes_checked;

  // The first three are shared between the sender and the receiver process.
  bit quiet = 1'b0;     // no idling on either side
  bit squeeze = 1'b0;   // asks the receiver for one long hold-off
  bit holding = 1'b0;   // the receiver is in its long hold-off
  int gap_pct = 0;      // chance in percent of an idle burst before a byte
  int bytes_sent = 0;
  int strings_sent = 0;
  int phases_run = 0;

  multi_mode_string_hash dut (.*);

  string_hash_checker hash_check (.*);

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Offers one byte and returns at the edge where it is taken. The valid is
  // left high so that back-to-back bytes need no second assignment in a step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Draws one string of random length. Letters are favored so that the
  // case-folding and letters-only modes see plenty of them, and high bytes
  // are favored for the sign extension in rot13.
  task automatic send_string();
    int len;
    logic [7:0] b;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: b = UPPER_A + 8'($urandom_range(0, 25));
        3, 4:    b = LOWER_A + 8'($urandom_range(0, 25));
        5, 6:    b = 8'($urandom_range(128, 255));
        default: b = 8'($urandom_range(1, 255));
      endcase
      send_byte(b);
    end
    send_byte(END_OF_STRING);
    strings_sent++;
  endtask

  // Writes the mode and then the multiplier as two words on the configuration
  // port. The bits above the mode field carry noise that the block drops.
  task automatic write_config(input logic [4:0] mode_sel, input logic [31:0] mult);
    logic [31:0] noise;
    noise = $urandom;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_MODE;
    cfg_data  <= {noise[31:5], mode_sel};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_IDX_BKDR;
    cfg_data  <= mult;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    phases_run++;
  endtask

  // Stops offering bytes and waits until every expected hash word has come
  // out. Counts are read at the falling edge, after the checker has settled.
  task automatic drain_hashes();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_hashes != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The receiver alternates between runs of taking words and bursts of stall.
  // Once it is asked to, it holds off for a long stretch so that the block's
  // result register fills and the input side is stalled in turn.
  initial begin : receiver
    int n;
    forever begin
      if (squeeze) begin
        squeeze = 1'b0;
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holding = 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 40);
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [4:0]  phase_mode;
    logic [31:0] phase_mult;
    int          phase_start;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The reset mode is djb2: first an empty string, which
    // must give the start value, then the byte extremes.
    send_byte(END_OF_STRING);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(END_OF_STRING);
    drain_hashes();

    // rot13 with bytes on both sides of the sign boundary.
    write_config(MODE_ROT13, BKDR_RESET);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(END_OF_STRING);
    drain_hashes();

    // Letters-only: the boundary letters and the characters just outside them.
    write_config(MODE_LOAAT, BKDR_RESET);
    send_byte(8'h41);
    send_byte(8'h5A);
    send_byte(8'h61);
    send_byte(8'h7A);
    send_byte(8'h40);
    send_byte(8'h5B);
    send_byte(8'h60);
    send_byte(8'h7B);
    send_byte(END_OF_STRING);
    drain_hashes();

    // An unused mode code leaves the hash at zero.
    write_config(MODE_UNUSED_TOP, BKDR_RESET);
    send_byte(8'h78);
    send_byte(END_OF_STRING);
    drain_hashes();

    // Mode change in the middle of a string: BKDR with the largest multiplier
    // starts the string, maBKDR with a zero multiplier finishes it.
    write_config(MODE_BKDR, 32'hFFFF_FFFF);
    send_byte(8'h61);
    send_byte(8'h62);
    drain_hashes();
    write_config(MODE_MABKDR, 32'd0);
    send_byte(8'h63);
    send_byte(END_OF_STRING);
    drain_hashes();

    // Empty strings in modes with a final mix and a nonzero start value.
    write_config(MODE_OAAT, BKDR_RESET);
    send_byte(END_OF_STRING);
    drain_hashes();
    write_config(MODE_FNV1, BKDR_RESET);
    send_byte(END_OF_STRING);
    drain_hashes();

    // Random part. The first seventeen phases walk every mode in order; the
    // rest pick modes at random, now and then one of the unused codes.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph <= int'(MODE_LOAAT)) phase_mode = 5'(ph);
      else if ($urandom_range(0, 9) == 0) phase_mode = 5'($urandom_range(17, 31));
      else phase_mode = 5'($urandom_range(0, 16));
      case ($urandom_range(0, 3))
        0:       phase_mult = 32'd0;
        1:       phase_mult = 32'hFFFF_FFFF;
        2:       phase_mult = BKDR_RESET;
        default: phase_mult = $urandom;
      endcase
      write_config(phase_mode, phase_mult);

      quiet = (ph >= NUM_PHASES - QUIET_PHASES);
      if (quiet || ph == SQUEEZE_PHASE) gap_pct = 0;
      else case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 40;
      endcase
      // The long hold-off must be under way before the bytes of this phase
      // go out, so that they pile up behind the waiting hash word.
      if (ph == SQUEEZE_PHASE) begin
        squeeze = 1'b1;
        wait (holding);
      end

      phase_start = bytes_sent;
      while (bytes_sent < phase_start + BYTES_PER_PHASE) send_string();

      // Sometimes the phase ends inside a string, so that the next setting
      // carries on from the running hash.
      if (!quiet && $urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(1, 255)));
      drain_hashes();
    end

    $display("Sent %0d bytes in %0d strings over %0d settings, covering all 17 modes",
             bytes_sent, strings_sent, phases_run);
    $display("plus unused codes and multiplier extremes; %0d hash words checked, %0d failures.",
             hashes_checked, failures);
    if (failures == 0) begin
      $display("multi_mode_string_hash regression: pass");
    end else begin
      $display("multi_mode_string_hash regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d hash words still expected.", pending_hashes);
    $display("multi_mode_string_hash regression: fail");
    $finish;
  end

endmodule
